[design/magnetometer_hard_iron_calibrator_defines.svh]
// assertion macros used by the checker file
`ifndef MAGNETOMETER_HARD_IRON_CALIBRATOR_DEFINES_SVH
`define MAGNETOMETER_HARD_IRON_CALIBRATOR_DEFINES_SVH

// same-cycle implication, held off during reset
`define MHIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define MHIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mhic_pkg.sv]
package mhic_pkg;

  // sample and bus widths
  localparam int SAMPLE_W     = 16;
  localparam int IN_TDATA_W   = 6 * SAMPLE_W;
  localparam int OUT_TDATA_W  = 72;
  localparam int CFG_DATA_W   = 16;
  localparam int DEF_NUM_BINS = 36;

  // heading cordic
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_SH    = 14;

  // queue between front and back
  localparam int FIFO_DEPTH = 2;

  // register reset values
  localparam logic [15:0] COS_SQ_RESET = 16'd61146;
  localparam logic [3:0]  RATIO_RESET  = 4'd5;
  localparam logic [7:0]  FULL_RESET   = 8'd6;

  // register indexes
  localparam logic [1:0] REG_COS_SQ = 2'd0;
  localparam logic [1:0] REG_RATIO  = 2'd1;
  localparam logic [1:0] REG_FULL   = 2'd2;

  // orientation codes
  localparam logic [1:0] ORIENT_NONE = 2'd0;
  localparam logic [1:0] ORIENT_X    = 2'd1;
  localparam logic [1:0] ORIENT_Y    = 2'd2;
  localparam logic [1:0] ORIENT_Z    = 2'd3;

  // calibration phases
  localparam logic [1:0] PHASE_XY   = 2'd0;
  localparam logic [1:0] PHASE_XZ   = 2'd1;
  localparam logic [1:0] PHASE_DONE = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0] orient;
    sample_t    fx;
    sample_t    fy;
    sample_t    fz;
  } mhic_item_t;

  // settings the back part needs
  typedef struct packed {
    logic [3:0] ratio;
    logic [7:0] full_count;
  } mhic_cfg_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:    r = 32'h20000000;
        5'd1:    r = 32'h12E4051E;
        5'd2:    r = 32'h09FB385B;
        5'd3:    r = 32'h051111D4;
        5'd4:    r = 32'h028B0D43;
        5'd5:    r = 32'h0145D7E1;
        5'd6:    r = 32'h00A2F61E;
        5'd7:    r = 32'h00517C55;
        5'd8:    r = 32'h0028BE53;
        5'd9:    r = 32'h00145F2F;
        5'd10:   r = 32'h000A2F98;
        5'd11:   r = 32'h000517CC;
        5'd12:   r = 32'h00028BE6;
        5'd13:   r = 32'h000145F3;
        5'd14:   r = 32'h0000A2FA;
        5'd15:   r = 32'h0000517D;
        5'd16:   r = 32'h000028BE;
        5'd17:   r = 32'h0000145F;
        5'd18:   r = 32'h00000A30;
        5'd19:   r = 32'h00000518;
        5'd20:   r = 32'h0000028C;
        5'd21:   r = 32'h00000146;
        5'd22:   r = 32'h000000A3;
        5'd23:   r = 32'h00000051;
        default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction

endpackage

[design/mhic_fifo.sv]
module mhic_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mhic_pkg::mhic_item_t push_item,
  output logic                full,
  input  logic                pop,
  output mhic_pkg::mhic_item_t pop_item,
  output logic                empty
);
  import mhic_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  mhic_item_t      slots [FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/mhic_front.sv]
module mhic_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mhic_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [15:0]                        cos_sq,
  output logic                               push,
  output mhic_pkg::mhic_item_t               push_item,
  input  logic                               full
);
  import mhic_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQ   = 3'd1;
  localparam logic [2:0] F_SUM  = 3'd2;
  localparam logic [2:0] F_MUL  = 3'd3;
  localparam logic [2:0] F_CMP  = 3'd4;

  logic [2:0]              state;
  logic [1:0]              k;
  sample_t                 accel [3];
  sample_t                 fx;
  sample_t                 fy;
  sample_t                 fz;
  logic [31:0]             a2 [3];
  logic [31:0]             g2;
  logic [47:0]             cg;
  logic signed [31:0]      sq;
  logic [1:0]              orient;

  assign s_tready = (state == F_IDLE);
  assign sq       = accel[k] * accel[k];

  // first axis whose squared share passes the tilt test
  always_comb begin
    orient = ORIENT_NONE;
    if ({a2[0], 16'd0} > cg) begin
      orient = ORIENT_X;
    end else if ({a2[1], 16'd0} > cg) begin
      orient = ORIENT_Y;
    end else if ({a2[2], 16'd0} > cg) begin
      orient = ORIENT_Z;
    end
  end

  assign push      = (state == F_CMP) && !full;
  assign push_item = '{orient: orient, fx: fx, fy: fy, fz: fz};

  // accept, square three axes on one multiplier, scale and compare
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      k     <= 2'd0;
    end else begin
      case (state)
        F_IDLE: begin
          if (s_tvalid) begin
            accel[0] <= s_tdata[SAMPLE_W-1:0];
            accel[1] <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            accel[2] <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
            fx       <= s_tdata[4*SAMPLE_W-1:3*SAMPLE_W];
            fy       <= s_tdata[5*SAMPLE_W-1:4*SAMPLE_W];
            fz       <= s_tdata[6*SAMPLE_W-1:5*SAMPLE_W];
            k        <= 2'd0;
            state    <= F_SQ;
          end
        end
        F_SQ: begin
          a2[k] <= sq;
          if (k == 2'd2) begin
            state <= F_SUM;
          end else begin
            k <= k + 2'd1;
          end
        end
        F_SUM: begin
          g2    <= a2[0] + a2[1] + a2[2];
          state <= F_MUL;
        end
        F_MUL: begin
          cg    <= 48'(cos_sq) * 48'(g2);
          state <= F_CMP;
        end
        F_CMP: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

[design/mhic_back.sv]
module mhic_back #(
  parameter int NUM_BINS = mhic_pkg::DEF_NUM_BINS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               empty,
  output logic                               pop,
  input  mhic_pkg::mhic_item_t               pop_item,
  input  mhic_pkg::mhic_cfg_t                cfg,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mhic_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import mhic_pkg::*;

  localparam int BIN_W   = $clog2(NUM_BINS);
  localparam int CNT_W   = $clog2(NUM_BINS + 1);
  localparam int PROD_W  = 32 + CNT_W;

  localparam logic [3:0] B_IDLE   = 4'd0;
  localparam logic [3:0] B_MINMAX = 4'd1;
  localparam logic [3:0] B_SQ     = 4'd2;
  localparam logic [3:0] B_RATIO  = 4'd3;
  localparam logic [3:0] B_CINIT  = 4'd4;
  localparam logic [3:0] B_CORDIC = 4'd5;
  localparam logic [3:0] B_BIN    = 4'd6;
  localparam logic [3:0] B_WAIT   = 4'd7;
  localparam logic [3:0] B_RDATA  = 4'd8;
  localparam logic [3:0] B_OUT    = 4'd9;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [33:0] Z_TOP = 34'sh3FFFFFFF;

  // offset = floor((max + min) / 2), zero before any sample on the axis
  function automatic sample_t offset_of(input sample_t mx, input sample_t mn);
    logic signed [SAMPLE_W:0] s;
    begin
      s = (SAMPLE_W+1)'(mx) + (SAMPLE_W+1)'(mn);
      if (mx < mn) begin
        return '0;
      end
      return s[SAMPLE_W:1];
    end
  endfunction

  logic [3:0]              state;
  logic [1:0]              phase;
  mhic_item_t              item;
  logic                    upd;
  logic                    plane_xz;
  logic                    valid;
  sample_t                 fmax [3];
  sample_t                 fmin [3];
  logic [1:0]              sq_step;
  logic [33:0]             off2;
  logic [33:0]             spr2;
  logic signed [35:0]      cx;
  logic signed [35:0]      cy;
  logic signed [33:0]      cz;
  logic [4:0]              it;
  logic [1:0]              quad;
  logic [5:0]              bin;
  logic [CNT_W-1:0]        cov_xy;
  logic [CNT_W-1:0]        cov_xz;

  // bin count memories
  logic [7:0]              mem_xy [NUM_BINS];
  logic [7:0]              mem_xz [NUM_BINS];
  logic [NUM_BINS-1:0]     vld_xy;
  logic [NUM_BINS-1:0]     vld_xz;
  logic [7:0]              rd_xy;
  logic [7:0]              rd_xz;
  logic                    rdv_xy;
  logic                    rdv_xz;
  logic [BIN_W-1:0]        rd_addr;

  // coverage sweep
  logic                    sweep_run;
  logic                    sweep_pend;
  logic [BIN_W-1:0]        sweep_addr;
  logic [CNT_W-1:0]        sw_xy;
  logic [CNT_W-1:0]        sw_xz;
  logic                    sweep_busy;
  logic                    start;

  // plane operands
  sample_t                 fu;
  sample_t                 fv;
  sample_t                 max_u;
  sample_t                 min_u;
  sample_t                 max_v;
  sample_t                 min_v;
  sample_t                 ou;
  sample_t                 ov;
  sample_t                 off_x;
  sample_t                 off_y;
  sample_t                 off_z;
  logic signed [17:0]      sq_op;
  logic signed [35:0]      sq_prod;
  logic [7:0]              r2;
  logic [41:0]             rprod;
  logic signed [17:0]      du;
  logic signed [17:0]      dv;
  logic signed [17:0]      wx;
  logic signed [17:0]      wy;
  logic signed [35:0]      xs;
  logic signed [35:0]      ys;
  logic signed [33:0]      atan_s;
  logic [29:0]             zc;
  logic [PROD_W-1:0]       bprod;
  logic [CNT_W-1:0]        braw;
  logic [7:0]              val_xy;
  logic [7:0]              val_xz;
  logic [7:0]              old_cnt;
  logic [7:0]              new_cnt;
  logic                    gain;
  logic [1:0]              ph_new;
  logic [5:0]              cov_xy_o;
  logic [5:0]              cov_xz_o;
  logic [5:0]              bin_o;

  assign start      = (state == B_IDLE) && !empty;
  assign pop        = start;
  assign sweep_busy = sweep_run || sweep_pend;

  // axes of the plane in work: xy uses u = x, v = y; xz uses u = z, v = x
  assign fu    = plane_xz ? item.fz : item.fx;
  assign fv    = plane_xz ? item.fx : item.fy;
  assign max_u = plane_xz ? fmax[2] : fmax[0];
  assign min_u = plane_xz ? fmin[2] : fmin[0];
  assign max_v = plane_xz ? fmax[0] : fmax[1];
  assign min_v = plane_xz ? fmin[0] : fmin[1];
  assign ou    = offset_of(max_u, min_u);
  assign ov    = offset_of(max_v, min_v);
  assign off_x = offset_of(fmax[0], fmin[0]);
  assign off_y = offset_of(fmax[1], fmin[1]);
  assign off_z = offset_of(fmax[2], fmin[2]);

  // shared squarer operand
  always_comb begin
    case (sq_step)
      2'd0:    sq_op = 18'(ou);
      2'd1:    sq_op = 18'(ov);
      2'd2:    sq_op = 18'(max_u) - 18'(min_u);
      default: sq_op = 18'(max_v) - 18'(min_v);
    endcase
  end
  assign sq_prod = 36'(sq_op) * 36'(sq_op);

  // ratio test operands
  assign r2    = {4'd0, cfg.ratio} * {4'd0, cfg.ratio};
  assign rprod = 42'(r2) * 42'(spr2);

  // corrected field and its mirror
  assign du = 18'(fu) - 18'(ou);
  assign dv = 18'(fv) - 18'(ov);
  assign wx = -du;
  assign wy = -dv;

  // cordic step terms
  assign xs     = cx >>> it;
  assign ys     = cy >>> it;
  assign atan_s = signed'({2'b00, atan_turn(it)});

  // angle to sector
  always_comb begin
    if (cz < 0) begin
      zc = '0;
    end else if (cz > Z_TOP) begin
      zc = Z_TOP[29:0];
    end else begin
      zc = cz[29:0];
    end
  end
  assign bprod = PROD_W'({quad, zc}) * PROD_W'(NUM_BINS);
  assign braw  = bprod[PROD_W-1:32];

  // count update for the selected bin
  assign val_xy  = rdv_xy ? rd_xy : 8'd0;
  assign val_xz  = rdv_xz ? rd_xz : 8'd0;
  assign old_cnt = plane_xz ? val_xz : val_xy;
  assign new_cnt = (old_cnt == 8'hFF) ? old_cnt : old_cnt + 8'd1;
  assign gain    = (new_cnt >= cfg.full_count) && !(old_cnt >= cfg.full_count);

  // phase after this item and saturated coverage outputs
  always_comb begin
    ph_new = phase;
    if (phase == PHASE_XY && cov_xy == CNT_W'(NUM_BINS)) begin
      ph_new = PHASE_XZ;
    end else if (phase == PHASE_XZ && cov_xz == CNT_W'(NUM_BINS)) begin
      ph_new = PHASE_DONE;
    end
  end
  assign cov_xy_o = (int'(cov_xy) > 63) ? 6'd63 : 6'(cov_xy);
  assign cov_xz_o = (int'(cov_xz) > 63) ? 6'd63 : 6'(cov_xz);
  assign bin_o    = valid ? bin : 6'd0;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      phase    <= PHASE_XY;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        fmax[i] <= SAMPLE_MIN;
        fmin[i] <= SAMPLE_MAX;
      end
    end else begin
      // the output state sets valid itself when it loads a new item
      if (m_tvalid && m_tready && state != B_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!empty) begin
            item     <= pop_item;
            upd      <= (phase != PHASE_DONE) &&
                        (pop_item.orient == ORIENT_Z || pop_item.orient == ORIENT_Y);
            plane_xz <= (pop_item.orient == ORIENT_Y);
            off2     <= '0;
            spr2     <= '0;
            sq_step  <= 2'd0;
            state    <= B_MINMAX;
          end
        end
        B_MINMAX: begin
          // x is in both planes, y only in xy, z only in xz
          if (upd) begin
            if (item.fx > fmax[0]) fmax[0] <= item.fx;
            if (item.fx < fmin[0]) fmin[0] <= item.fx;
            if (!plane_xz) begin
              if (item.fy > fmax[1]) fmax[1] <= item.fy;
              if (item.fy < fmin[1]) fmin[1] <= item.fy;
            end else begin
              if (item.fz > fmax[2]) fmax[2] <= item.fz;
              if (item.fz < fmin[2]) fmin[2] <= item.fz;
            end
          end
          state <= B_SQ;
        end
        B_SQ: begin
          if (sq_step[1]) begin
            spr2 <= spr2 + sq_prod[33:0];
          end else begin
            off2 <= off2 + sq_prod[33:0];
          end
          sq_step <= sq_step + 2'd1;
          if (sq_step == 2'd3) begin
            state <= B_RATIO;
          end
        end
        B_RATIO: begin
          valid <= upd && (42'(off2) < rprod);
          state <= (upd && (42'(off2) < rprod)) ? B_CINIT : B_WAIT;
        end
        B_CINIT: begin
          cz <= '0;
          it <= 5'd0;
          if (du == 0 && dv == 0) begin
            bin   <= 6'(NUM_BINS / 2);
            state <= B_WAIT;
          end else if (dv == 0 && du < 0) begin
            bin   <= 6'(NUM_BINS - 1);
            state <= B_WAIT;
          end else begin
            if (wx > 0 && wy >= 0) begin
              quad <= 2'd0;
              cx   <= 36'(wx) <<< CORDIC_SH;
              cy   <= 36'(wy) <<< CORDIC_SH;
            end else if (wx <= 0 && wy > 0) begin
              quad <= 2'd1;
              cx   <= 36'(wy) <<< CORDIC_SH;
              cy   <= 36'(-wx) <<< CORDIC_SH;
            end else if (wx < 0 && wy <= 0) begin
              quad <= 2'd2;
              cx   <= 36'(-wx) <<< CORDIC_SH;
              cy   <= 36'(-wy) <<< CORDIC_SH;
            end else begin
              quad <= 2'd3;
              cx   <= 36'(-wy) <<< CORDIC_SH;
              cy   <= 36'(wx) <<< CORDIC_SH;
            end
            // on an axis the angle is the quadrant start
            if ((wx > 0 && wy == 0) || (wx == 0 && wy > 0) ||
                (wx < 0 && wy == 0) || (wx == 0 && wy < 0)) begin
              state <= B_BIN;
            end else begin
              state <= B_CORDIC;
            end
          end
        end
        B_CORDIC: begin
          if (cy > 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + atan_s;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - atan_s;
          end
          it <= it + 5'd1;
          if (it == 5'(CORDIC_STEPS - 1)) begin
            state <= B_BIN;
          end
        end
        B_BIN: begin
          bin   <= (braw > CNT_W'(NUM_BINS - 1)) ? 6'(NUM_BINS - 1) : 6'(braw);
          state <= B_WAIT;
        end
        B_WAIT: begin
          if (!sweep_busy) begin
            if (valid) begin
              state <= B_RDATA;
            end else begin
              cov_xy <= sw_xy;
              cov_xz <= sw_xz;
              state  <= B_OUT;
            end
          end
        end
        B_RDATA: begin
          cov_xy <= plane_xz ? sw_xy : sw_xy + CNT_W'(gain);
          cov_xz <= plane_xz ? sw_xz + CNT_W'(gain) : sw_xz;
          state  <= B_OUT;
        end
        B_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {cov_xz_o, cov_xy_o, off_z, off_y, off_x,
                         bin_o, valid, valid, ph_new, item.orient};
            phase    <= ph_new;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // sweep both count memories, one entry a cycle, counting covered bins
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_run  <= 1'b0;
      sweep_pend <= 1'b0;
    end else begin
      sweep_pend <= sweep_run;
      if (start) begin
        sweep_run  <= 1'b1;
        sweep_addr <= '0;
        sw_xy      <= '0;
        sw_xz      <= '0;
      end else begin
        if (sweep_run) begin
          if (sweep_addr == BIN_W'(NUM_BINS - 1)) begin
            sweep_run <= 1'b0;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        if (sweep_pend) begin
          sw_xy <= sw_xy + CNT_W'(val_xy >= cfg.full_count);
          sw_xz <= sw_xz + CNT_W'(val_xz >= cfg.full_count);
        end
      end
    end
  end

  assign rd_addr = sweep_run ? sweep_addr : bin[BIN_W-1:0];

  // count memories with registered read
  always_ff @(posedge clk) begin
    rd_xy  <= mem_xy[rd_addr];
    rd_xz  <= mem_xz[rd_addr];
    rdv_xy <= vld_xy[rd_addr];
    rdv_xz <= vld_xz[rd_addr];
    if (state == B_RDATA && !plane_xz) begin
      mem_xy[bin[BIN_W-1:0]] <= new_cnt;
    end
    if (state == B_RDATA && plane_xz) begin
      mem_xz[bin[BIN_W-1:0]] <= new_cnt;
    end
  end

  // written marks, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_xy <= '0;
      vld_xz <= '0;
    end else if (state == B_RDATA) begin
      if (plane_xz) begin
        vld_xz[bin[BIN_W-1:0]] <= 1'b1;
      end else begin
        vld_xy[bin[BIN_W-1:0]] <= 1'b1;
      end
    end
  end

endmodule

[design/magnetometer_hard_iron_calibrator.sv]
// channel   | dir | handshake          | payload
// s_axis    | in  | s_tvalid/s_tready  | s_tdata: accel x,y,z, field x,y,z
// m_axis    | out | m_tvalid/m_tready  | m_tdata: orientation .. covered_xz
// cfg       | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// the front takes a new item only once it has pushed the last one into the queue;
// the back's pace per item is set by the sweep over the bin count memories (the
// 24-step cordic runs alongside it). a two-entry queue lets the front keep accepting
// while the back works or the output waits. reset is synchronous; bin counts
// read as zero until written, so no clearing pass is run.
module magnetometer_hard_iron_calibrator #(
  parameter int NUM_BINS = mhic_pkg::DEF_NUM_BINS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // accel_x, accel_y, accel_z, field_x, field_y, field_z (16 bits each)
  input  logic [mhic_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // orientation[1:0], calib_phase[3:2], plane_valid[4], bin_updated[5],
  // angle_bin[11:6], offset_x[27:12], offset_y[43:28], offset_z[59:44],
  // covered_xy[65:60], covered_xz[71:66]
  output logic [mhic_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [mhic_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mhic_pkg::*;

  logic [15:0]  cos_sq;
  mhic_cfg_t    cfg;
  logic         push;
  mhic_item_t   push_item;
  logic         full;
  logic         pop;
  mhic_item_t   pop_item;
  logic         empty;

  assign cfg_ready = 1'b1;

  // settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_sq         <= COS_SQ_RESET;
      cfg.ratio      <= RATIO_RESET;
      cfg.full_count <= FULL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COS_SQ: cos_sq         <= cfg_data[15:0];
        REG_RATIO:  cfg.ratio      <= cfg_data[3:0];
        REG_FULL:   cfg.full_count <= cfg_data[7:0];
        default:    ;
      endcase
    end
  end

  mhic_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cos_sq    (cos_sq),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  mhic_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  mhic_back #(
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop      (pop),
    .pop_item (pop_item),
    .cfg      (cfg),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[design/mhic_checker.sv]
`include "magnetometer_hard_iron_calibrator_defines.svh"

module mhic_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [mhic_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  // a stalled result holds
  `MHIC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // bin update goes with a passed plane test
  `MHIC_ASSERT_NOW(a_valid_pair, m_tvalid, m_tdata[4] == m_tdata[5], "plane_valid and bin_updated differ")

  // no sector reported without an update
  `MHIC_ASSERT_NOW(a_bin_zero, m_tvalid && !m_tdata[5], m_tdata[11:6] == 6'd0, "angle_bin set without update")

  // phase code stays in range
  `MHIC_ASSERT_NOW(a_phase_code, m_tvalid, m_tdata[3:2] != 2'd3, "calib_phase out of range")

endmodule

bind magnetometer_hard_iron_calibrator mhic_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/magnetometer_hard_iron_calibrator_tb.sv]
module magnetometer_hard_iron_calibrator_tb;
  import mhic_pkg::*;

  localparam int NBINS = 36;

  // result fields, packed so that orientation lands in the low bits
  typedef struct packed {
    logic [5:0]         cov_xz;
    logic [5:0]         cov_xy;
    logic signed [15:0] off_z;
    logic signed [15:0] off_y;
    logic signed [15:0] off_x;
    logic [5:0]         bin;
    logic               upd;
    logic               pvalid;
    logic [1:0]         phase;
    logic [1:0]         orient;
  } cal_result_t;

  typedef struct {
    logic [15:0] ax, ay, az, fx, fy, fz;
    bit          typed;
    cal_result_t want;
  } sample_row_t;

  // atan(2^-i) in 2^-32 turn
  localparam longint ATAN_STEP [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  // accel_x, accel_y, accel_z, field_x, field_y, field_z
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  // orientation, calib_phase, plane_valid, bin_updated, angle_bin,
  // offset_x, offset_y, offset_z, covered_xy, covered_xz
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [1:0]             cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  magnetometer_hard_iron_calibrator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // calibrator shadow state
  longint      cos_sq_lim, ratio_lim, full_lim;
  longint      fmax [3];
  longint      fmin [3];
  int          xy_hits [NBINS];
  int          xz_hits [NBINS];
  logic [1:0]  cal_phase;
  cal_result_t pending_results [$];

  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          bins_counted = 0;
  int          hold_cycles = 0;
  bit          hold_done = 0;
  bit          stim_done = 0;
  int          max_phase = 0;

  always #5 clk = ~clk;

  function automatic longint axis_offset(int k);
    if (fmax[k] < fmin[k]) return 0;
    return (fmax[k] + fmin[k]) >>> 1;
  endfunction

  // heading sector of the corrected field, integer cordic
  function automatic int heading_sector(longint du, longint dv);
    longint wx, wy, x, y, z, xs, ys, q;
    longint unsigned phi, sect;
    wx = -du;
    wy = -dv;
    z = 0;
    if (du == 0 && dv == 0) return NBINS / 2;
    if (dv == 0 && du < 0) return NBINS - 1;
    if (wx > 0 && wy >= 0) begin
      q = 0; x = wx; y = wy;
    end else if (wx <= 0 && wy > 0) begin
      q = 1; x = wy; y = -wx;
    end else if (wx < 0 && wy <= 0) begin
      q = 2; x = -wx; y = -wy;
    end else begin
      q = 3; x = -wy; y = wx;
    end
    if (y != 0) begin
      x = x * 16384;
      y = y * 16384;
      for (int i = 0; i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += ATAN_STEP[i];
        end else begin
          x -= ys; y += xs; z -= ATAN_STEP[i];
        end
      end
      if (z < 0) z = 0;
      if (z > 64'h3FFFFFFF) z = 64'h3FFFFFFF;
    end
    phi = q * 64'h40000000 + z;
    sect = (phi * NBINS) >> 32;
    if (sect > NBINS - 1) sect = NBINS - 1;
    return int'(sect);
  endfunction

  // min/max tracking, ratio test and bin count for one plane
  function automatic bit plane_step(int u, int v, longint f[3], bit xz_plane,
                                    output int sect);
    longint ou, ov, su, sv, off2, spr2;
    foreach (f[k]) begin
      if (k == u || k == v) begin
        if (f[k] > fmax[k]) fmax[k] = f[k];
        if (f[k] < fmin[k]) fmin[k] = f[k];
      end
    end
    sect = 0;
    ou = axis_offset(u);
    ov = axis_offset(v);
    su = fmax[u] - fmin[u];
    sv = fmax[v] - fmin[v];
    off2 = ou * ou + ov * ov;
    spr2 = su * su + sv * sv;
    if (!(off2 < ratio_lim * ratio_lim * spr2)) return 0;
    sect = heading_sector(f[u] - ou, f[v] - ov);
    if (xz_plane) begin
      if (xz_hits[sect] < 255) xz_hits[sect]++;
    end else begin
      if (xy_hits[sect] < 255) xy_hits[sect]++;
    end
    return 1;
  endfunction

  function automatic cal_result_t predict_sample(logic [IN_TDATA_W-1:0] d);
    cal_result_t r;
    longint a [3];
    longint f [3];
    longint unsigned g2, lhs;
    int nxy, nxz, sect;
    bit ok;
    r = '0;
    ok = 0;
    sect = 0;
    for (int k = 0; k < 3; k++) begin
      a[k] = longint'($signed(d[16*k +: 16]));
      f[k] = longint'($signed(d[16*(k+3) +: 16]));
    end
    g2 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
    for (int k = 0; k < 3; k++) begin
      lhs = (a[k] * a[k]) << 16;
      if (r.orient == ORIENT_NONE && lhs > cos_sq_lim * g2) r.orient = 2'(k + 1);
    end
    if (cal_phase != PHASE_DONE) begin
      if (r.orient == ORIENT_Z) ok = plane_step(0, 1, f, 0, sect);
      else if (r.orient == ORIENT_Y) ok = plane_step(2, 0, f, 1, sect);
    end
    nxy = 0;
    nxz = 0;
    for (int i = 0; i < NBINS; i++) begin
      if (xy_hits[i] >= full_lim) nxy++;
      if (xz_hits[i] >= full_lim) nxz++;
    end
    if (cal_phase == PHASE_XY && nxy == NBINS) cal_phase = PHASE_XZ;
    else if (cal_phase == PHASE_XZ && nxz == NBINS) cal_phase = PHASE_DONE;
    r.phase  = cal_phase;
    r.pvalid = ok;
    r.upd    = ok;
    r.bin    = ok ? 6'(sect) : 6'd0;
    r.off_x  = 16'(axis_offset(0));
    r.off_y  = 16'(axis_offset(1));
    r.off_z  = 16'(axis_offset(2));
    r.cov_xy = nxy > 63 ? 6'd63 : 6'(nxy);
    r.cov_xz = nxz > 63 ? 6'd63 : 6'(nxz);
    return r;
  endfunction

  task automatic report_field(string fname, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  // offer one item with random gaps, predict it once it is taken
  task automatic send_sample(logic [IN_TDATA_W-1:0] d, bit typed, cal_result_t want,
                             bit no_gaps);
    cal_result_t r;
    while (!no_gaps && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_sample(d);
    if (int'(r.phase) > max_phase) max_phase = r.phase;
    if (r.upd) bins_counted++;
    pending_results.push_back(typed ? want : r);
    items_sent++;
  endtask

  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_COS_SQ: cos_sq_lim = val;
      REG_RATIO:  ratio_lim = val[3:0];
      REG_FULL:   full_lim = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] cs, logic [15:0] ratio, logic [15:0] full);
    drain_block();
    write_reg(REG_COS_SQ, cs);
    write_reg(REG_RATIO, ratio);
    write_reg(REG_FULL, full);
  endtask

  function automatic logic [IN_TDATA_W-1:0] pack_sample(
    logic [15:0] ax, ay, az, fx, fy, fz);
    return {fz, fy, fx, az, ay, ax};
  endfunction

  // one sample of the given kind: noise, level board, or board on its side
  function automatic logic [IN_TDATA_W-1:0] make_sample(int kind, int cx, int cy,
                                                        int cz);
    real ang, rad;
    int u, v, g, t1, t2;
    logic [15:0] w [6];
    for (int k = 0; k < 6; k++) w[k] = 16'($urandom);
    ang = $urandom_range(35999) * 3.14159265 / 18000.0;
    rad = 2500 + $urandom_range(1500);
    u = int'(rad * $cos(ang));
    v = int'(rad * $sin(ang));
    g = $urandom_range(1) ? 16000 : -16000;
    t1 = int'($urandom_range(4000)) - 2000;
    t2 = int'($urandom_range(4000)) - 2000;
    if (kind == 1) begin
      w[0] = 16'(t1); w[1] = 16'(t2); w[2] = 16'(g);
      w[3] = 16'(cx + u); w[4] = 16'(cy + v);
    end else if (kind == 2) begin
      w[0] = 16'(t1); w[1] = 16'(g); w[2] = 16'(t2);
      w[5] = 16'(cz + u); w[3] = 16'(cx + v);
    end
    return {w[5], w[4], w[3], w[2], w[1], w[0]};
  endfunction

  task automatic random_run(int n, int mix_noise, int plane);
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = ($urandom_range(99) < mix_noise) ? 0 : plane;
      if (plane == 3) kind = $urandom_range(2);
      send_sample(make_sample(kind, 1500, -800, 600), 0, '0,
                  items_sent >= 400 && items_sent < 500);
    end
  endtask

  // directed rows
  sample_row_t rows [$];

  task automatic add_row(int ax, ay, az, fx, fy, fz, bit typed = 0,
                         cal_result_t want = '0);
    sample_row_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.fx = 16'(fx); s.fy = 16'(fy); s.fz = 16'(fz);
    s.typed = typed;
    s.want = want;
    rows.push_back(s);
  endtask

  // result checking and output stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        cal_result_t got, want;
        got = cal_result_t'(m_tdata);
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, m_tdata);
        end else begin
          want = pending_results.pop_front();
          report_field("orientation", want.orient, got.orient);
          report_field("calib_phase", want.phase, got.phase);
          report_field("plane_valid", want.pvalid, got.pvalid);
          report_field("bin_updated", want.upd, got.upd);
          report_field("angle_bin", want.bin, got.bin);
          report_field("offset_x", want.off_x, got.off_x);
          report_field("offset_y", want.off_y, got.off_y);
          report_field("offset_z", want.off_z, got.off_z);
          report_field("covered_xy", want.cov_xy, got.cov_xy);
          report_field("covered_xz", want.cov_xz, got.cov_xz);
        end
      end
      // one long hold-off so the input side backs up
      if (!hold_done && results_seen == 250) begin
        hold_done <= 1'b1;
        hold_cycles <= 400;
        m_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 1'b0;
      end else if (results_seen >= 500 && results_seen < 600) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 22);
      end
    end
  end

  initial begin
    #20000000;
    $display("magnetometer_hard_iron_calibrator_tb failed");
    $finish;
  end

  initial begin
    cal_result_t w;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_COS_SQ;
    cfg_data = '0;
    cos_sq_lim = COS_SQ_RESET;
    ratio_lim = RATIO_RESET;
    full_lim = FULL_RESET;
    for (int k = 0; k < 3; k++) begin
      fmax[k] = -32768;
      fmin[k] = 32767;
    end
    for (int i = 0; i < NBINS; i++) begin
      xy_hits[i] = 0;
      xz_hits[i] = 0;
    end
    cal_phase = PHASE_XY;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero accel, x vertical, equal extremes: nothing tracked
    w = '0;
    add_row(0, 0, 0, 1234, -999, 77, 1, w);
    w.orient = ORIENT_X;
    add_row(16000, 0, 0, 32767, -32768, 5, 1, w);
    w.orient = ORIENT_NONE;
    add_row(-32768, -32768, -32768, -32768, 32767, -1, 1, w);
    // first level sample: single point, no spread yet
    w.orient = ORIENT_Z; w.off_x = 100; w.off_y = 200;
    add_row(0, 0, 16000, 100, 200, 50, 1, w);
    add_row(0, 0, 16000, 300, -200, 50);
    // zero corrected field, then a heading of exactly a full turn
    add_row(100, -100, 16000, 200, 0, 0);
    add_row(0, 0, -16000, 100, 0, 0);
    add_row(0, 0, 16000, 250, 150, 0);
    add_row(0, 0, 16000, 32767, -32768, 0);
    add_row(0, 0, 16000, -32768, 32767, 0);
    add_row(0, 0, 16000, 150, -100, -32768);
    // board on its side, xz plane
    add_row(0, 16000, 0, 50, 0, -300);
    add_row(0, -16000, 0, -400, 0, 700);
    add_row(0, 16000, 0, 200, 9, 100);
    add_row(0, 16000, 0, 32767, 0, -32768);
    add_row(0, 16000, 0, -32768, 0, 32767);
    // accel extremes and a tilt past the limit
    add_row(32767, 0, 0, 1, 2, 3);
    add_row(0, -32768, 0, 1, 2, 3);
    add_row(0, 0, 32767, 10, 20, 30);
    add_row(-32768, -32768, 0, 4, 5, 6);
    add_row(0, 9000, 16000, 7, 8, 9);
    add_row(0, 0, -32768, -5, 5, 0);
    foreach (rows[i])
      send_sample({rows[i].fz, rows[i].fy, rows[i].fx, rows[i].az, rows[i].ay,
                   rows[i].ax}, rows[i].typed, rows[i].want, 0);

    // default settings, mixed traffic
    random_run(80, 20, 3);
    // tightest tilt, widest ratio, top full count: saturate one bin
    set_regs(16'hFFFF, 16'd15, 16'd255);
    for (int i = 0; i < 270; i++)
      send_sample(pack_sample(16'd0, 16'd0, 16'd16000, 16'd2500, 16'(-300), 16'd0),
                  0, '0, items_sent >= 400 && items_sent < 500);
    random_run(30, 40, 1);
    // zero tilt limit, tightest ratio
    set_regs(16'h0000, 16'd1, 16'd200);
    random_run(60, 30, 3);
    // ratio of zero never passes
    set_regs(COS_SQ_RESET, 16'd0, 16'd6);
    random_run(30, 10, 3);
    // one hit per bin: sweep xy, then xz, then finished calibration
    set_regs(COS_SQ_RESET, 16'd15, 16'd1);
    random_run(200, 10, 1);
    random_run(200, 10, 2);
    random_run(20, 30, 3);
    // full count of zero covers every bin
    set_regs(COS_SQ_RESET, 16'd5, 16'd0);
    random_run(20, 30, 3);

    drain_block();
    repeat (100) @(posedge clk);
    $display("%0d samples, %0d results checked, %0d bin updates, last phase %0d",
             items_sent, results_seen, bins_counted, max_phase);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("magnetometer_hard_iron_calibrator_tb passed");
    end else begin
      $display("magnetometer_hard_iron_calibrator_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/mhic_pkg.sv
design/mhic_fifo.sv
design/mhic_front.sv
design/mhic_back.sv
design/magnetometer_hard_iron_calibrator.sv
design/mhic_checker.sv
tb/magnetometer_hard_iron_calibrator_tb.sv
